>>> design/mpq_pkg.sv
// shared types, codes and defaults for the min priority queue
`timescale 1ns / 1ps

package mpq_pkg;

    localparam int MPQ_DEPTH = 16;

    // command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_LIST   = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_STEP,
        S_INS_CMP,
        S_REM_RD,
        S_REM_OUT,
        S_LST_RD,
        S_LST_OUT
    } t_state;

    typedef struct packed {
        logic               valid;
        logic signed [31:0] value;
        logic [1:0]         status;
        logic               last;
    } t_result;

endpackage

>>> design/mpq_ram.sv
// value store: one write port, one read port with registered read data
`timescale 1ns / 1ps

module mpq_ram #(
    parameter int DEPTH = mpq_pkg::MPQ_DEPTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  logic signed [31:0] i_wdata,
    input  logic [AW-1:0]      i_raddr,
    output logic signed [31:0] o_rdata
);
    import mpq_pkg::*;

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/min_priority_queue_top.sv
// top level of the min priority queue: sequencer, pointers and result register
`timescale 1ns / 1ps

// bounded min priority queue of signed 32-bit values
// - command channel: an item (i_command, i_value) is taken at a rising edge with
//   start high and busy low; busy stays high while the item is worked on
// - result channel: o_valid strobes for one cycle per result with o_result_value,
//   o_status and o_last; the receiver cannot stall, so results are never held
// - values sit in a ring in a single-port-read memory, ascending from the head
//   pointer; one signed compare unit and the memory read port do all the work
// - insert: each held value larger than the new one is moved up one place,
//   then the new value is written; the result follows in the next cycle
// - remove: head read, then pointer advance together with the result
// - list: a memory read, then an emit, for each of the occupancy results
// - empty remove or list, and insert when full, answer in the cycle after
//   acceptance without leaving idle; command code three is dropped silently
// - the registered memory read data puts a read state before each use of it
// - reset empties the queue (occupancy and head cleared); memory contents
//   are not cleared since no entry beyond occupancy is ever used

module min_priority_queue_top #(
    parameter int DEPTH = mpq_pkg::MPQ_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_command,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    output logic signed [31:0] o_result_value,
    output logic [1:0]         o_status,
    output logic               o_last
);
    import mpq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // sequencer state and pointers
    t_state             r_state, n_state;
    logic [CW-1:0]      r_occ, n_occ;      // number of held values
    logic [CW-1:0]      r_k, n_k;          // logical position being worked on
    logic [AW-1:0]      r_head, n_head;    // physical slot of the smallest value
    logic signed [31:0] r_value, n_value;  // value of the insert in flight
    t_result            r_res, n_res;

    // memory port signals
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic signed [31:0] mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic signed [31:0] mem_rdata;

    logic accept;
    logic occ_full;
    logic occ_empty;

    assign accept    = start && (r_state == S_IDLE);
    assign occ_full  = (r_occ == CW'(DEPTH));
    assign occ_empty = (r_occ == '0);

    // logical position to physical slot in the ring
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] pos);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, pos[AW-1:0]};
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    mpq_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_command)
                        CMD_INSERT: if (!occ_full)  n_state = S_INS_STEP;
                        CMD_REMOVE: if (!occ_empty) n_state = S_REM_RD;
                        CMD_LIST:   if (!occ_empty) n_state = S_LST_RD;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_INS_STEP: n_state = (r_k == '0) ? S_IDLE : S_INS_CMP;
            S_INS_CMP:  n_state = (mem_rdata > r_value) ? S_INS_STEP : S_IDLE;
            S_REM_RD:   n_state = S_REM_OUT;
            S_REM_OUT:  n_state = S_IDLE;
            S_LST_RD:   n_state = S_LST_OUT;
            S_LST_OUT:  n_state = (r_k == r_occ - CW'(1)) ? S_IDLE : S_LST_RD;
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath control and results
    always_comb begin
        n_occ     = r_occ;
        n_k       = r_k;
        n_head    = r_head;
        n_value   = r_value;
        n_res     = '0;
        mem_we    = 1'b0;
        mem_waddr = phys(r_head, r_k);
        mem_wdata = r_value;
        mem_raddr = phys(r_head, r_k);
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_value = i_value;
                    case (i_command)
                        CMD_INSERT: begin
                            if (occ_full) begin
                                n_res.valid  = 1'b1;
                                n_res.status = ST_FULL;
                                n_res.last   = 1'b1;
                            end else begin
                                n_k = r_occ;
                            end
                        end
                        CMD_REMOVE: begin
                            if (occ_empty) begin
                                n_res.valid  = 1'b1;
                                n_res.status = ST_EMPTY;
                                n_res.last   = 1'b1;
                            end
                        end
                        CMD_LIST: begin
                            if (occ_empty) begin
                                n_res.valid  = 1'b1;
                                n_res.status = ST_EMPTY;
                                n_res.last   = 1'b1;
                            end else begin
                                n_k = '0;
                            end
                        end
                        default: n_res = '0;
                    endcase
                end
            end
            S_INS_STEP: begin
                if (r_k == '0) begin
                    // reached the head: new value goes in front
                    mem_we       = 1'b1;
                    n_occ        = r_occ + CW'(1);
                    n_res.valid  = 1'b1;
                    n_res.status = ST_OK;
                    n_res.last   = 1'b1;
                end else begin
                    mem_raddr = phys(r_head, r_k - CW'(1));
                end
            end
            S_INS_CMP: begin
                mem_we = 1'b1;
                if (mem_rdata > r_value) begin
                    // larger neighbor moves up one place
                    mem_wdata = mem_rdata;
                    n_k       = r_k - CW'(1);
                end else begin
                    n_occ        = r_occ + CW'(1);
                    n_res.valid  = 1'b1;
                    n_res.status = ST_OK;
                    n_res.last   = 1'b1;
                end
            end
            S_REM_RD: begin
                mem_raddr = r_head;
            end
            S_REM_OUT: begin
                n_head       = phys(r_head, CW'(1));
                n_occ        = r_occ - CW'(1);
                n_res.valid  = 1'b1;
                n_res.value  = mem_rdata;
                n_res.status = ST_OK;
                n_res.last   = 1'b1;
            end
            S_LST_RD: begin
                mem_raddr = phys(r_head, r_k);
            end
            S_LST_OUT: begin
                n_k          = r_k + CW'(1);
                n_res.valid  = 1'b1;
                n_res.value  = mem_rdata;
                n_res.status = ST_OK;
                n_res.last   = (r_k == r_occ - CW'(1));
            end
            default: n_res = '0;
        endcase
    end

    // control and payload registers; only state, occupancy, head and result valid are reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_head      <= '0;
            r_res.valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_head      <= n_head;
            r_res.valid <= n_res.valid;
        end
        r_k          <= n_k;
        r_value      <= n_value;
        r_res.value  <= n_res.value;
        r_res.status <= n_res.status;
        r_res.last   <= n_res.last;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_res.valid;
    assign o_result_value = r_res.value;
    assign o_status       = r_res.status;
    assign o_last         = r_res.last;

`ifndef SYNTH
    // occupancy never passes the store depth
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(DEPTH))
        else $error("occupancy above depth");

    // a full report only comes while the store is full
    a_full_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> occ_full)
        else $error("full reported on a store with room");

    // error results carry a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_result_value == '0))
        else $error("nonzero value on error result");

    // a remove on a non-empty store starts with a head read
    a_rem_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_command == CMD_REMOVE && !occ_empty) |=> (r_state == S_REM_RD))
        else $error("remove did not start reading the head");

    // a non-final result only comes from a list still in progress
    a_list_more: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> (r_state == S_LST_RD))
        else $error("non-final result outside a list");
`endif

endmodule
